FILE: src/bsbz_pkg.sv
// Shared types, constants and arithmetic helpers of the B-spline to Bezier converter.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package bsbz_pkg;

    localparam int COORD_BITS = 32;
    localparam int AXES       = 3;

    // |2a+b| <= 3 * 2^(COORD_BITS-1) fits in COORD_BITS+1 bits
    localparam int MAG_BITS   = COORD_BITS + 1;
    // split point kept even so that 2^LO_BITS = 1 (mod 3)
    localparam int LO_BITS    = 2 * (MAG_BITS / 4);
    localparam int HI_BITS    = MAG_BITS - LO_BITS;
    localparam int SUM_BITS   = HI_BITS + 1;
    localparam int RSHIFT     = SUM_BITS + 1;
    localparam int RECIP_BITS = RSHIFT - 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;

    // floor(m/3) = hi*HI_RECIP + floor((hi+lo)/3)
    localparam logic [LO_BITS-1:0] HI_RECIP =
        LO_BITS'(((64'd1 << LO_BITS) - 64'd1) / 64'd3);
    // rounded-up reciprocal, exact for values below 2^SUM_BITS
    localparam logic [RECIP_BITS-1:0] LO_RECIP =
        RECIP_BITS'(((64'd1 << RSHIFT) / 64'd3) + 64'd1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_BITS-1:0] QCOUNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

    localparam logic [2:0] SEEN_FIRST = 3'd3;
    localparam logic [2:0] SEEN_SAT   = 3'd4;

    // work kinds handed from front to back
    localparam logic [1:0] KIND_FIRST = 2'd0;
    localparam logic [1:0] KIND_MID   = 2'd1;
    localparam logic [1:0] KIND_LAST4 = 2'd2;
    localparam logic [1:0] KIND_LASTN = 2'd3;

    localparam logic [1:0] ROLE_JOIN   = 2'd0;
    localparam logic [1:0] ROLE_INNER1 = 2'd1;
    localparam logic [1:0] ROLE_INNER2 = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    // index 0 = x, 1 = y, 2 = z
    typedef logic [AXES-1:0][COORD_BITS-1:0] vec_t;

    typedef struct packed {
        logic [1:0] kind;
        vec_t       h0;
        vec_t       h1;
        vec_t       h2;
        vec_t       cur;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } qwr_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } qrd_t;

    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] mag;
    } sm_t;

    typedef struct packed {
        logic [MAG_BITS-1:0] hi;
        logic [SUM_BITS-2:0] lo;
    } dp_t;

    // (a+b)/2 truncated toward zero
    function automatic coord_t avg2(input coord_t a, input coord_t b);
        logic signed [COORD_BITS:0] s;
        logic signed [COORD_BITS:0] t;
        s = (COORD_BITS+1)'(a) + (COORD_BITS+1)'(b);
        t = s + {{COORD_BITS{1'b0}}, s[COORD_BITS]};
        avg2 = t[COORD_BITS:1];
    endfunction

    // sign and magnitude of 2a+b
    function automatic sm_t sign_mag(input coord_t a, input coord_t b);
        logic signed [COORD_BITS+1:0] s;
        logic [COORD_BITS+1:0]        m;
        sm_t                          r;
        s = ((COORD_BITS+2)'(a) <<< 1) + (COORD_BITS+2)'(b);
        m = s[COORD_BITS+1] ? -s : s;
        r.neg = s[COORD_BITS+1];
        r.mag = m[MAG_BITS-1:0];
        sign_mag = r;
    endfunction

    // partial quotients of m/3
    function automatic dp_t div_parts(input logic [MAG_BITS-1:0] m);
        logic [HI_BITS-1:0]   h;
        logic [LO_BITS-1:0]   l;
        logic [SUM_BITS-1:0]  v;
        logic [PROD_BITS-1:0] lp;
        dp_t                  r;
        h = m[MAG_BITS-1:LO_BITS];
        l = m[LO_BITS-1:0];
        v = SUM_BITS'(h) + SUM_BITS'(l);
        r.hi = MAG_BITS'(h) * MAG_BITS'(HI_RECIP);
        lp = PROD_BITS'(v) * PROD_BITS'(LO_RECIP);
        r.lo = lp[PROD_BITS-1:RSHIFT];
        div_parts = r;
    endfunction

    // combine partial quotients and restore the sign
    function automatic coord_t div_finish(input logic neg, input dp_t d);
        logic [MAG_BITS-1:0] q;
        logic [MAG_BITS-1:0] r;
        q = d.hi + MAG_BITS'(d.lo);
        r = neg ? -q : q;
        div_finish = r[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/bsbz_if.sv
// Valid/ready channel interfaces for control points in and Bezier points out.
// Depends on bsbz_pkg for the coordinate width.
`default_nettype none

interface bsbz_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bsbz_pkg::COORD_BITS-1:0] pos_x;
    logic signed [bsbz_pkg::COORD_BITS-1:0] pos_y;
    logic signed [bsbz_pkg::COORD_BITS-1:0] pos_z;
    logic                                  final_point;

    modport source (output valid, pos_x, pos_y, pos_z, final_point, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, final_point, output ready);
endinterface

interface bsbz_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bsbz_pkg::COORD_BITS-1:0] out_x;
    logic signed [bsbz_pkg::COORD_BITS-1:0] out_y;
    logic signed [bsbz_pkg::COORD_BITS-1:0] out_z;
    logic [1:0]                            role;
    logic                                  run_end;
    logic                                  curve_end;

    modport source (output valid, out_x, out_y, out_z, role, run_end, curve_end,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, role, run_end, curve_end,
                    output ready);
endinterface

`default_nettype wire

FILE: src/bsbz_front.sv
// Front end: takes control points, keeps the three-point history and point count,
// and classifies each point into a work entry for the queue. Depends on bsbz_pkg, bsbz_if.
`default_nettype none

module bsbz_front (
    input  logic              clk,
    input  logic              rst_n,
    bsbz_in_if.sink           ctrl_pts,
    input  logic              q_full,
    output bsbz_pkg::qwr_t    qwr
);

    bsbz_pkg::vec_t hist_reg [3];
    bsbz_pkg::vec_t hist_next [3];
    logic [2:0]     seen_reg;
    logic [2:0]     seen_next;
    bsbz_pkg::vec_t cur_pt;
    logic           accept;
    logic           last;

    assign ctrl_pts.ready = !q_full;
    assign accept = ctrl_pts.valid && ctrl_pts.ready;
    assign last   = ctrl_pts.final_point;

    always_comb
    begin
        cur_pt[0] = ctrl_pts.pos_x;
        cur_pt[1] = ctrl_pts.pos_y;
        cur_pt[2] = ctrl_pts.pos_z;
    end

    always_comb
    begin
        qwr.push        = accept && (seen_reg >= bsbz_pkg::SEEN_FIRST);
        qwr.entry.h0    = hist_reg[0];
        qwr.entry.h1    = hist_reg[1];
        qwr.entry.h2    = hist_reg[2];
        qwr.entry.cur   = cur_pt;
        if (last)
            qwr.entry.kind = (seen_reg == bsbz_pkg::SEEN_FIRST) ?
                             bsbz_pkg::KIND_LAST4 : bsbz_pkg::KIND_LASTN;
        else
            qwr.entry.kind = (seen_reg == bsbz_pkg::SEEN_FIRST) ?
                             bsbz_pkg::KIND_FIRST : bsbz_pkg::KIND_MID;
    end

    always_comb
    begin
        seen_next    = seen_reg;
        hist_next[0] = hist_reg[0];
        hist_next[1] = hist_reg[1];
        hist_next[2] = hist_reg[2];
        if (accept)
        begin
            if (last)
            begin
                seen_next    = '0;
                hist_next[0] = '0;
                hist_next[1] = '0;
                hist_next[2] = '0;
            end
            else
            begin
                if (seen_reg < bsbz_pkg::SEEN_SAT)
                    seen_next = seen_reg + 3'd1;
                hist_next[0] = hist_reg[1];
                hist_next[1] = hist_reg[2];
                hist_next[2] = cur_pt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            hist_reg[2] <= '0;
        end
        else
        begin
            seen_reg    <= seen_next;
            hist_reg[0] <= hist_next[0];
            hist_reg[1] <= hist_next[1];
            hist_reg[2] <= hist_next[2];
        end
    end

endmodule

`default_nettype wire

FILE: src/bsbz_queue.sv
// Short FIFO of work entries between the front end and the back end.
// Depends on bsbz_pkg.
`default_nettype none

module bsbz_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  bsbz_pkg::qwr_t    qwr,
    output logic              full,
    output bsbz_pkg::qrd_t    head,
    input  logic              pop
);

    bsbz_pkg::entry_t                  mem_reg [bsbz_pkg::QUEUE_DEPTH];
    logic [bsbz_pkg::QPTR_BITS-1:0]    wr_ptr_reg;
    logic [bsbz_pkg::QPTR_BITS-1:0]    wr_ptr_next;
    logic [bsbz_pkg::QPTR_BITS-1:0]    rd_ptr_reg;
    logic [bsbz_pkg::QPTR_BITS-1:0]    rd_ptr_next;
    logic [bsbz_pkg::QCNT_BITS-1:0]    count_reg;
    logic [bsbz_pkg::QCNT_BITS-1:0]    count_next;

    assign full       = (count_reg == bsbz_pkg::QCOUNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = qwr.push ? wr_ptr_reg + bsbz_pkg::QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + bsbz_pkg::QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (qwr.push && !pop)
            count_next = count_reg + bsbz_pkg::QCNT_BITS'(1);
        else if (pop && !qwr.push)
            count_next = count_reg - bsbz_pkg::QCNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (qwr.push)
            mem_reg[wr_ptr_reg] <= qwr.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/bsbz_back.sv
// Back end: three-stage divide-by-three pipeline for the thirds, then an emitter
// that sequences the Bezier points into an output register. Depends on bsbz_pkg, bsbz_if.
`default_nettype none

module bsbz_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bsbz_pkg::qrd_t    head,
    output logic              pop,
    bsbz_out_if.source        bez_pts
);

    localparam int A = bsbz_pkg::AXES;

    // stage 1: 2a+b and a+2b as sign/magnitude, plus the midpoint
    logic                                 p1_valid_reg;
    bsbz_pkg::entry_t                     p1_entry_reg;
    bsbz_pkg::vec_t                       p1_avg_reg;
    bsbz_pkg::sm_t [A-1:0]                p1_f_reg;
    bsbz_pkg::sm_t [A-1:0]                p1_g_reg;
    bsbz_pkg::vec_t                       p1_avg_next;
    bsbz_pkg::sm_t [A-1:0]                p1_f_next;
    bsbz_pkg::sm_t [A-1:0]                p1_g_next;

    // stage 2: partial quotients
    logic                                 p2_valid_reg;
    bsbz_pkg::entry_t                     p2_entry_reg;
    bsbz_pkg::vec_t                       p2_avg_reg;
    logic [A-1:0]                         p2_fneg_reg;
    logic [A-1:0]                         p2_gneg_reg;
    bsbz_pkg::dp_t [A-1:0]                p2_f_reg;
    bsbz_pkg::dp_t [A-1:0]                p2_g_reg;
    bsbz_pkg::dp_t [A-1:0]                p2_f_next;
    bsbz_pkg::dp_t [A-1:0]                p2_g_next;

    // stage 3: finished thirds
    logic                                 p3_valid_reg;
    bsbz_pkg::entry_t                     p3_entry_reg;
    bsbz_pkg::vec_t                       p3_avg_reg;
    bsbz_pkg::vec_t                       p3_f_reg;
    bsbz_pkg::vec_t                       p3_g_reg;
    bsbz_pkg::vec_t                       p3_f_next;
    bsbz_pkg::vec_t                       p3_g_next;

    // emitter
    logic                                 cur_valid_reg;
    bsbz_pkg::entry_t                     cur_entry_reg;
    bsbz_pkg::vec_t                       cur_avg_reg;
    bsbz_pkg::vec_t                       cur_f_reg;
    bsbz_pkg::vec_t                       cur_g_reg;
    logic [1:0]                           idx_reg;
    logic [1:0]                           idx_next;
    bsbz_pkg::vec_t                       prev_g_reg;
    bsbz_pkg::vec_t                       e_vec;
    bsbz_pkg::vec_t                       res;
    logic [1:0]                           res_role;
    logic                                 is_four;
    logic [1:0]                           last_idx;
    logic                                 fire;
    logic                                 done;
    logic                                 load;
    logic                                 adv;

    // output register
    logic                                 out_valid_reg;
    bsbz_pkg::vec_t                       out_pt_reg;
    logic [1:0]                           out_role_reg;
    logic                                 out_run_end_reg;
    logic                                 out_curve_end_reg;

    assign is_four  = (cur_entry_reg.kind == bsbz_pkg::KIND_LAST4) ||
                      (cur_entry_reg.kind == bsbz_pkg::KIND_LASTN);
    assign last_idx = is_four ? 2'd3 : 2'd2;
    assign fire     = cur_valid_reg && (!out_valid_reg || bez_pts.ready);
    assign done     = fire && (idx_reg == last_idx);
    assign load     = !cur_valid_reg || done;
    // the whole pipe moves in lockstep, held only when stage 3 cannot hand over
    assign adv      = !p3_valid_reg || load;
    assign pop      = adv && head.valid;
    assign idx_next = load ? 2'd0 : (fire ? idx_reg + 2'd1 : idx_reg);

    always_comb
    begin
        for (int a = 0; a < A; a++)
        begin
            p1_f_next[a]   = bsbz_pkg::sign_mag(head.entry.h1[a], head.entry.h2[a]);
            p1_g_next[a]   = bsbz_pkg::sign_mag(head.entry.h2[a], head.entry.h1[a]);
            p1_avg_next[a] = bsbz_pkg::avg2(head.entry.h1[a], head.entry.h2[a]);
            p2_f_next[a]   = bsbz_pkg::div_parts(p1_f_reg[a].mag);
            p2_g_next[a]   = bsbz_pkg::div_parts(p1_g_reg[a].mag);
            p3_f_next[a]   = bsbz_pkg::div_finish(p2_fneg_reg[a], p2_f_reg[a]);
            p3_g_next[a]   = bsbz_pkg::div_finish(p2_gneg_reg[a], p2_g_reg[a]);
        end
    end

    // join point uses the third on interior segments, the midpoint on the closing one
    always_comb
    begin
        for (int a = 0; a < A; a++)
            e_vec[a] = bsbz_pkg::avg2(prev_g_reg[a],
                           (cur_entry_reg.kind == bsbz_pkg::KIND_MID) ?
                           cur_f_reg[a] : cur_avg_reg[a]);
    end

    always_comb
    begin
        unique case (cur_entry_reg.kind)
            bsbz_pkg::KIND_FIRST:
            begin
                unique case (idx_reg)
                    2'd0:    res = cur_entry_reg.h0;
                    2'd1:    res = cur_entry_reg.h1;
                    default: res = cur_avg_reg;
                endcase
            end
            bsbz_pkg::KIND_MID:
            begin
                unique case (idx_reg)
                    2'd0:    res = e_vec;
                    2'd1:    res = cur_f_reg;
                    default: res = cur_g_reg;
                endcase
            end
            bsbz_pkg::KIND_LAST4:
            begin
                unique case (idx_reg)
                    2'd0:    res = cur_entry_reg.h0;
                    2'd1:    res = cur_entry_reg.h1;
                    2'd2:    res = cur_entry_reg.h2;
                    default: res = cur_entry_reg.cur;
                endcase
            end
            default:
            begin
                unique case (idx_reg)
                    2'd0:    res = e_vec;
                    2'd1:    res = cur_avg_reg;
                    2'd2:    res = cur_entry_reg.h2;
                    default: res = cur_entry_reg.cur;
                endcase
            end
        endcase
    end

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    res_role = bsbz_pkg::ROLE_JOIN;
            2'd1:    res_role = bsbz_pkg::ROLE_INNER1;
            2'd2:    res_role = bsbz_pkg::ROLE_INNER2;
            default: res_role = bsbz_pkg::ROLE_JOIN;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_entry_reg <= head.entry;
            p1_avg_reg   <= p1_avg_next;
            p1_f_reg     <= p1_f_next;
            p1_g_reg     <= p1_g_next;
            p2_entry_reg <= p1_entry_reg;
            p2_avg_reg   <= p1_avg_reg;
            p2_f_reg     <= p2_f_next;
            p2_g_reg     <= p2_g_next;
            for (int a = 0; a < A; a++)
            begin
                p2_fneg_reg[a] <= p1_f_reg[a].neg;
                p2_gneg_reg[a] <= p1_g_reg[a].neg;
            end
            p3_entry_reg <= p2_entry_reg;
            p3_avg_reg   <= p2_avg_reg;
            p3_f_reg     <= p3_f_next;
            p3_g_reg     <= p3_g_next;
        end
        if (load)
        begin
            cur_entry_reg <= p3_entry_reg;
            cur_avg_reg   <= p3_avg_reg;
            cur_f_reg     <= p3_f_reg;
            cur_g_reg     <= p3_g_reg;
        end
        if (done)
        begin
            if (cur_entry_reg.kind == bsbz_pkg::KIND_FIRST)
                prev_g_reg <= cur_avg_reg;
            else if (cur_entry_reg.kind == bsbz_pkg::KIND_MID)
                prev_g_reg <= cur_g_reg;
        end
        if (fire)
        begin
            out_pt_reg        <= res;
            out_role_reg      <= res_role;
            out_run_end_reg   <= (idx_reg == last_idx);
            out_curve_end_reg <= is_four && (idx_reg == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                p1_valid_reg <= head.valid;
                p2_valid_reg <= p1_valid_reg;
                p3_valid_reg <= p2_valid_reg;
            end
            if (load)
                cur_valid_reg <= p3_valid_reg;
            idx_reg <= idx_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (bez_pts.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign bez_pts.valid     = out_valid_reg;
    assign bez_pts.out_x     = out_pt_reg[0];
    assign bez_pts.out_y     = out_pt_reg[1];
    assign bez_pts.out_z     = out_pt_reg[2];
    assign bez_pts.role      = out_role_reg;
    assign bez_pts.run_end   = out_run_end_reg;
    assign bez_pts.curve_end = out_curve_end_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && !is_four |-> idx_reg != 2'd3)
        else $error("three-point entry stepped past its last result");

    a_p3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg && !adv |=> p3_valid_reg)
        else $error("stage 3 entry dropped while the emitter was busy");

    a_curve_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_curve_end_reg |->
            out_run_end_reg && (out_role_reg == bsbz_pkg::ROLE_JOIN))
        else $error("curve end flagged on a point that does not close a run");

endmodule

`default_nettype wire

FILE: src/bspline_to_bezier_converter.sv
// Top level of the cubic B-spline to Bezier converter: front end, entry queue, back end.
// Depends on bsbz_pkg, bsbz_if, bsbz_front, bsbz_queue, bsbz_back.
`default_nettype none

// Control points come in on ctrl_pts one per transfer and are taken whenever
// the four-entry work queue has room; the first three points of a curve only
// fill the history and give no results. From the fourth point on, each point
// gives three Bezier points and the final point four, delivered on bez_pts one
// per cycle from a registered output while bez_pts is ready, so the single
// result channel sets the sustained rate. The thirds go through a three-stage
// divide-by-three pipeline and then the emitter, which sequences the results
// into the output register. run_end marks the last result of each point,
// curve_end the final point of the curve, after which a new curve starts.
module bspline_to_bezier_converter (
    input  logic       clk,
    input  logic       rst_n,
    bsbz_in_if.sink    ctrl_pts,
    bsbz_out_if.source bez_pts
);

    bsbz_pkg::qwr_t qwr;
    bsbz_pkg::qrd_t head;
    logic           q_full;
    logic           pop;

    bsbz_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_pts (ctrl_pts),
        .q_full   (q_full),
        .qwr      (qwr)
    );

    bsbz_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qwr   (qwr),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    bsbz_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .bez_pts (bez_pts)
    );

endmodule

`default_nettype wire
